// File: design/mawu_pkg.sv
package mawu_pkg;

    // Width of one sample and of one average.
    localparam int SAMPLE_W = 16;

    // Default number of samples in the averaging window.
    localparam int WINDOW_LENGTH_DEF = 16;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SUM,
        ST_ABS,
        ST_START,
        ST_WAIT,
        ST_HOLD
    } t_state;

endpackage

// File: design/mawu_if.sv
// Channel that carries one sample per transaction.
interface mawu_sample_if
    import mawu_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Channel that carries one average per transaction.
interface mawu_average_if
    import mawu_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

// File: design/mawu_ring.sv
module mawu_ring
    import mawu_pkg::*;
#(
    parameter int DEPTH  = WINDOW_LENGTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic signed [SAMPLE_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic signed [SAMPLE_W-1:0] i_wr_data
);

    // Window samples; an entry read before it has been written is ignored during warm-up.
    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/mawu_div.sv
module mawu_div
    import mawu_pkg::*;
#(
    parameter int MAG_W = 20,
    parameter int DIV_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    // Restoring division, one quotient bit per cycle. The dividend shifts
    // out of the top of r_q while quotient bits shift in at the bottom.
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAG_W-1:0] r_q, n_q;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dvs, n_dvs;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    always_comb begin
        trial  = {r_rem, r_q[MAG_W-1]};
        diff   = trial - {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(MAG_W);
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff[DIV_W-1:0];
                n_q   = {r_q[MAG_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIV_W-1:0];
                n_q   = {r_q[MAG_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// File: design/moving_average_with_warmup_top.sv
// An accepted sample passes the delta, sum, absolute-value and start states
// and then the bit-serial divider, which has MAG_W = 16 + clog2(WINDOW_LENGTH)
// bits and produces one quotient bit per cycle, before its average is registered.
// The next sample is taken only once that average has been loaded for output.
// Reset (synchronous, active low) clears the running sum, write position,
// warm-up flag and output valid; the sample ring needs no clearing.
module moving_average_with_warmup_top
    import mawu_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mawu_sample_if.sink    i_in,
    mawu_average_if.source o_out
);

    // The sum of the window needs log2 of the length extra bits plus a sign.
    // Its magnitude fits in one bit less, which is what the divider takes.
    localparam int PTR_W = $clog2(WINDOW_LENGTH);
    localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);
    localparam int SUM_W = SAMPLE_W + PTR_W + 1;
    localparam int MAG_W = SUM_W - 1;
    localparam int DLT_W = SAMPLE_W + 1;

    t_state r_state, n_state;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [DLT_W-1:0]    r_delta;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic [PTR_W-1:0]           r_pos, n_pos;
    logic                       r_full, n_full;
    logic [CNT_W-1:0]           r_divisor, n_divisor;
    logic [MAG_W-1:0]           r_mag;
    logic                       r_neg;
    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_average, n_average;

    logic                       in_fire;
    logic                       out_free;
    logic                       load_out;
    logic                       div_start;
    logic                       div_done;
    logic [MAG_W-1:0]           div_quotient;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic signed [DLT_W-1:0]    old_ext;
    logic [SUM_W-1:0]           sum_abs;

    // The block takes a new sample whenever the sequencer is idle; a result
    // still waiting in the output register does not hold up the input side.
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    // The oldest sample is read at the write position in the cycle of the
    // input transaction and overwritten with the new sample in the cycle after it.
    mawu_ring #(
        .DEPTH (WINDOW_LENGTH),
        .ADDR_W(PTR_W)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rd_en  (in_fire),
        .i_rd_addr(r_pos),
        .o_rd_data(old_sample),
        .i_wr_en  (r_state == ST_DELTA),
        .i_wr_addr(r_pos),
        .i_wr_data(r_sample)
    );

    mawu_div #(
        .MAG_W(MAG_W),
        .DIV_W(CNT_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_mag),
        .i_divisor (r_divisor),
        .o_done    (div_done),
        .o_quotient(div_quotient)
    );

    // During warm-up nothing leaves the window, so the delta is the sample.
    assign old_ext   = r_full ? DLT_W'(old_sample) : '0;
    assign sum_abs   = r_sum[SUM_W-1] ? (-r_sum) : r_sum;
    assign div_start = (r_state == ST_START);

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_pos       = r_pos;
        n_full      = r_full;
        n_divisor   = r_divisor;
        n_out_valid = r_out_valid;
        n_average   = r_average;
        load_out    = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_DELTA;
                end
            end
            ST_DELTA: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                // Divide by the number of samples held, or by the full length.
                n_sum = r_sum + SUM_W'(r_delta);
                if (r_full) begin
                    n_divisor = CNT_W'(WINDOW_LENGTH);
                end else begin
                    n_divisor = CNT_W'(r_pos) + 1'b1;
                end
                // The ring fills when the last slot is written; the position
                // wraps there both in warm-up and in steady state.
                if (r_pos == PTR_W'(WINDOW_LENGTH - 1)) begin
                    n_pos  = '0;
                    n_full = 1'b1;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
                n_state = ST_ABS;
            end
            ST_ABS: begin
                n_state = ST_START;
            end
            ST_START: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // The quotient magnitude never exceeds 32768, so its low bits with
        // the sign restored give the truncated average exactly.
        if (load_out) begin
            n_out_valid = 1'b1;
            if (r_neg) begin
                n_average = -div_quotient[SAMPLE_W-1:0];
            end else begin
                n_average = div_quotient[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_pos       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_pos       <= n_pos;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
        r_divisor <= n_divisor;
        r_average <= n_average;
        if (in_fire) begin
            r_sample <= i_in.sample;
        end
        if (r_state == ST_DELTA) begin
            r_delta <= DLT_W'(r_sample) - old_ext;
        end
        if (r_state == ST_ABS) begin
            r_mag <= sum_abs[MAG_W-1:0];
            r_neg <= r_sum[SUM_W-1];
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.average = r_average;

    // The write position always stays inside the ring.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PTR_W'(WINDOW_LENGTH - 1))
        else $error("write position outside the ring");

    // Warm-up ends exactly when the position wraps to the first slot.
    a_full_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_full) |-> (r_pos == '0))
        else $error("window filled without wrapping the position");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_WAIT))
        else $error("divider finished outside the wait state");

    // A result is only loaded when the output register is free.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result overwrote an unread output");

endmodule

// File: tb/sv/moving_average_with_warmup_top_test.sv
module moving_average_with_warmup_top_test;
    import mawu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is tested at its default window length.
    localparam int WINDOW = WINDOW_LENGTH_DEF;

    // Reset is held for this many clock cycles at the start of the run.
    localparam int RESET_CYCLES = 11;

    // Per-item idle draw on either side runs from zero to this many cycles.
    localparam int MAX_GAP = 18;

    // Length of the one long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES = 400;

    // The watchdog ends the run after this many cycles without any transaction.
    // The worst honest gap is the hold-off above plus a divider pass and two
    // idle draws, so this leaves a wide margin.
    localparam int STALL_LIMIT = 4000;

    // Cycles allowed to pass after the last average.
    localparam int DRAIN_CYCLES = 60;

    // Number of random items after the directed part.
    localparam int RANDOM_ITEMS = 450;

    // Only this many mismatches are printed in full.
    localparam int MAX_REPORTS = 10;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Kinds of random bursts.
    typedef enum int {
        BURST_UNIFORM,
        BURST_EXTREME,
        BURST_NEAR_ZERO,
        BURST_CONSTANT
    } t_burst;

    // Keeps its own copy of the ring, the running sum and the warm-up flag,
    // and holds the averages that are still to come out, oldest first.
    class average_scoreboard;
        int      ring_q[WINDOW];
        int      window_total;
        int      next_slot;
        bit      ring_filled;
        t_sample pending_averages[$];
        int      mismatches;

        function new();
            window_total = 0;
            next_slot    = 0;
            ring_filled  = 1'b0;
            mismatches   = 0;
        endfunction

        // Works out the average that an accepted sample must produce.
        function void note_sample(t_sample value);
            int slot;
            int mean;
            slot = (next_slot >= WINDOW) ? 0 : next_slot;
            if (!ring_filled) begin
                ring_q[slot] = value;
                window_total += value;
                // Signed int division truncates toward zero.
                mean = window_total / (slot + 1);
                if (slot + 1 >= WINDOW) begin
                    ring_filled = 1'b1;
                    next_slot   = 0;
                end else begin
                    next_slot = slot + 1;
                end
            end else begin
                window_total = window_total - ring_q[slot] + value;
                ring_q[slot] = value;
                mean = window_total / WINDOW;
                next_slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
            end
            pending_averages.push_back(t_sample'(mean));
        endfunction

        // Compares an accepted average with the oldest one still pending.
        function void check_average(t_sample actual);
            t_sample wanted;
            if (pending_averages.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("average %0d arrived with none pending", actual);
                end
            end else begin
                wanted = pending_averages.pop_front();
                if (actual !== wanted) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("average mismatch: expected %0d, got %0d", wanted, actual);
                    end
                end
            end
        endfunction

        function int pending();
            return pending_averages.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mawu_sample_if  sample_ch ();
    mawu_average_if average_ch ();

    moving_average_with_warmup_top #(
        .WINDOW_LENGTH(WINDOW)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (sample_ch.sink),
        .o_out  (average_ch.source)
    );

    average_scoreboard averages = new();

    // Upper bounds of the idle draws of the two sides. The stimulus sets them
    // per burst, so that some stretches run with no idling at all.
    int  send_gap_max = MAX_GAP;
    int  take_gap_max = MAX_GAP;

    // Set once by the stimulus to make the receiver hold off for a long time.
    bit  hold_request = 1'b0;

    // Set by the monitor whenever a transaction takes place on either channel.
    bit  any_transaction;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Every input of the block is known from time zero on.
    initial begin
        i_rst_n          <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        average_ch.ready <= 1'b0;
    end

    // Both channels are sampled at the rising edge, before any of the
    // nonblocking updates of that edge take effect, so the values seen here
    // are the ones the block itself saw.
    always @(posedge i_clk) begin
        any_transaction = 1'b0;
        if (i_rst_n) begin
            if (sample_ch.valid && sample_ch.ready) begin
                averages.note_sample(sample_ch.sample);
                any_transaction = 1'b1;
            end
            if (average_ch.valid && average_ch.ready) begin
                averages.check_average(average_ch.average);
                any_transaction = 1'b1;
            end
        end
    end

    // Offers one sample after a random idle stretch and returns at the edge
    // where the transaction takes place. Valid stays high when the next item
    // follows with no gap, so it is never lowered and raised in one step.
    task automatic send_sample(input t_sample value);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do begin
            @(posedge i_clk);
        end while (!sample_ch.ready);
    endtask

    // Draws a sample for one item of a random burst.
    function automatic t_sample burst_sample(t_burst kind, t_sample held);
        t_sample value;
        case (kind)
            BURST_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: value = 16'sh8000;
                    1: value = 16'sh7fff;
                    2: value = -16'sd1;
                    3: value = 16'sd1;
                    default: value = '0;
                endcase
            end
            // Small values of both signs make the truncation toward zero
            // show up on most averages.
            BURST_NEAR_ZERO: value = t_sample'($signed($urandom_range(0, 16)) - 8);
            BURST_CONSTANT:  value = held;
            default:         value = t_sample'($urandom());
        endcase
        return value;
    endfunction

    // Receiver: for every average it idles a random number of cycles, then
    // raises ready until a transaction takes place. On request it holds off
    // for one long stretch while the sender keeps offering samples, so the
    // block fills up and stalls its input side.
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                average_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = $urandom_range(0, take_gap_max);
            if (gap > 0) begin
                average_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            average_ch.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!average_ch.valid);
        end
    end

    // Watchdog: counts consecutive cycles without a transaction after reset.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            #0.1;
            quiet_cycles = any_transaction ? 0 : quiet_cycles + 1;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main stimulus.
    initial begin
        t_sample directed_q[$];
        int      sent;
        int      run_length;
        int      settle;
        bit      hold_done;
        t_burst  kind;
        t_sample held;

        // The warm-up part of the directed list fills the ring with extremes and small values.
        // The second sample gives a sum of -1 over two samples, which must
        // truncate to zero, and the sixteenth is the item that fills the ring.
        // The items after it replace the oldest samples one by one.
        directed_q = '{
            16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
            16'sh7fff, -16'sd1,   16'sd1,    16'sd0,
            16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd3,
            -16'sd5,   16'sd7,    16'sh8000, 16'sh7fff,
            16'sh7fff, 16'sh8000, -16'sd1,   16'sd1,
            16'sd0,    -16'sd7
        };
        sent      = 0;
        hold_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_q[k]) begin
            send_sample(directed_q[k]);
        end

        // Random bursts. Each burst picks its kind of data and whether the two
        // sides idle, so that gaps fall on every phase of the divider and some
        // stretches run back to back. Constant bursts of an extreme longer
        // than the ring drive the running sum to its limits.
        while (sent < RANDOM_ITEMS) begin
            kind = t_burst'($urandom_range(0, 3));
            run_length = $urandom_range(1, 40);
            held = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
            if ($urandom_range(0, 2) == 0) begin
                held = t_sample'($urandom());
            end
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            if (!hold_done && sent >= RANDOM_ITEMS / 2) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            repeat (run_length) begin
                if (sent < RANDOM_ITEMS) begin
                    send_sample(burst_sample(kind, held));
                    sent++;
                end
            end
        end

        sample_ch.valid <= 1'b0;
        @(posedge i_clk);

        // Wait for every pending average; the watchdog covers a hang here.
        while (averages.pending() != 0) @(posedge i_clk);

        // A few more cycles show any surplus average the block might produce.
        settle = 0;
        while (settle < DRAIN_CYCLES) begin
            @(posedge i_clk);
            settle++;
        end

        if (averages.mismatches == 0 && averages.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
design/mawu_pkg.sv
design/mawu_if.sv
design/mawu_ring.sv
design/mawu_div.sv
design/moving_average_with_warmup_top.sv
tb/sv/moving_average_with_warmup_top_test.sv
